### sv/hmv_pkg.sv
// ----------------------------------------------------------------------------
// hmv_pkg
// Shared types and constants for the hermitian matrix-vector mac unit.
// ----------------------------------------------------------------------------
package hmv_pkg;

  localparam int MAX_RX  = 4;
  localparam int MAX_TX  = 4;
  localparam int MAX_SC  = 256;
  localparam int Y_DEPTH = MAX_RX * MAX_SC;
  localparam int Y_AW    = $clog2(Y_DEPTH);

  // configuration register indexes
  localparam logic [1:0] REG_RX_USED   = 2'd0;
  localparam logic [1:0] REG_TX_USED   = 2'd1;
  localparam logic [1:0] REG_SC_USED   = 2'd2;
  localparam logic [1:0] REG_FRAC_BITS = 2'd3;

  // product select codes, one per partial product of conj(h)*y
  localparam logic [1:0] PSEL_HR_YR = 2'd0;
  localparam logic [1:0] PSEL_HI_YI = 2'd1;
  localparam logic [1:0] PSEL_HR_YI = 2'd2;
  localparam logic [1:0] PSEL_HI_YR = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_clr;
  } mac_ctrl_t;

endpackage

### sv/hmv_mac.sv
// ----------------------------------------------------------------------------
// hmv_mac
// Shared 32x32 multiplier, 64-bit wrapping accumulators and shift/saturate.
// ----------------------------------------------------------------------------
module hmv_mac (
  input  logic                clk,
  input  logic                rst,
  input  hmv_pkg::mac_ctrl_t  ctrl,
  input  logic signed [31:0]  h_re,
  input  logic signed [31:0]  h_im,
  input  logic signed [31:0]  y_re,
  input  logic signed [31:0]  y_im,
  input  logic [4:0]          frac_bits,
  output logic signed [31:0]  sum_re,
  output logic signed [31:0]  sum_im
);

  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] prod;
  logic               prod_valid;
  logic [1:0]         prod_sel;
  logic [63:0]        acc_real;
  logic [63:0]        acc_imag;

  function automatic logic signed [31:0] shift_sat(input logic [63:0] u,
                                                   input logic [4:0]  f);
    logic signed [63:0] s;
    logic signed [31:0] r;
    s = $signed(u) >>> f;
    if (s > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (s < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  always_comb begin
    case (ctrl.mul_sel)
      hmv_pkg::PSEL_HR_YR: begin ma = h_re; mb = y_re; end
      hmv_pkg::PSEL_HI_YI: begin ma = h_im; mb = y_im; end
      hmv_pkg::PSEL_HR_YI: begin ma = h_re; mb = y_im; end
      default:             begin ma = h_im; mb = y_re; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod     <= ma * mb;
      prod_sel <= ctrl.mul_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc_real   <= '0;
      acc_imag   <= '0;
    end else begin
      prod_valid <= ctrl.mul_en;
      if (ctrl.acc_clr) begin
        acc_real <= '0;
        acc_imag <= '0;
      end else if (prod_valid) begin
        case (prod_sel)
          hmv_pkg::PSEL_HR_YR,
          hmv_pkg::PSEL_HI_YI: acc_real <= acc_real + prod;
          hmv_pkg::PSEL_HR_YI: acc_imag <= acc_imag + prod;
          default:             acc_imag <= acc_imag - prod;
        endcase
      end
    end
  end

  assign sum_re = shift_sat(acc_real, frac_bits);
  assign sum_im = shift_sat(acc_imag, frac_bits);

endmodule

### sv/hermitian_matrix_vector_mac_unit.sv
// ----------------------------------------------------------------------------
// hermitian_matrix_vector_mac_unit
// Matched filter H^H*y: y loads into a memory, channel items accumulate.
// ----------------------------------------------------------------------------
// load item: accepted back to back while the sequencer is idle
// channel item: memory read, four passes of the shared multiplier, final
//   accumulate; the last rx item of a pair then waits in the emit state until
//   the output register is free, and its result then shows on out_valid
// reset clears positions, accumulators and configuration registers to defaults; y memory is
//   not cleared and must be loaded before it is read
module hermitian_matrix_vector_mac_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic signed [31:0] val_re,
  input  logic signed [31:0] val_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_re,
  output logic signed [31:0] out_im,
  output logic [1:0]         tx_index,
  output logic [7:0]         sc_index,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int AW = hmv_pkg::Y_AW;

  hmv_pkg::state_t    state;
  hmv_pkg::state_t    state_next;
  hmv_pkg::mac_ctrl_t mac_ctrl;

  logic [2:0]  rx_used;
  logic [2:0]  tx_used;
  logic [8:0]  sc_used;
  logic [4:0]  frac_bits;
  logic [2:0]  nrx;
  logic [2:0]  ntx;
  logic [8:0]  nsc;

  logic [AW-1:0] load_pos;
  logic [1:0]    rx_pos;
  logic [7:0]    sc_pos;
  logic [1:0]    tx_pos;
  logic [1:0]    step;

  logic signed [31:0] h_re;
  logic signed [31:0] h_im;
  logic [63:0]        ymem [hmv_pkg::Y_DEPTH];
  logic [63:0]        y_rdata;

  logic          accept;
  logic          y_we;
  logic          y_rd;
  logic          emit_fire;
  logic          rx_more;
  logic          sc_more;
  logic          tx_more;
  logic [11:0]   total;
  logic [11:0]   ld_addr;
  logic [11:0]   ld_next;
  logic [AW-1:0] rd_addr;
  logic signed [31:0] sum_re;
  logic signed [31:0] sum_im;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_used   <= 3'd4;
      tx_used   <= 3'd4;
      sc_used   <= 9'd256;
      frac_bits <= 5'd15;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hmv_pkg::REG_RX_USED:   rx_used   <= cfg_data[2:0];
        hmv_pkg::REG_TX_USED:   tx_used   <= cfg_data[2:0];
        hmv_pkg::REG_SC_USED:   sc_used   <= cfg_data;
        hmv_pkg::REG_FRAC_BITS: frac_bits <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective sizes, zero acts as one and values above the maximum are clamped to it
  always_comb begin
    nrx = (rx_used == 3'd0) ? 3'd1 :
          (rx_used > 3'(hmv_pkg::MAX_RX)) ? 3'(hmv_pkg::MAX_RX) : rx_used;
    ntx = (tx_used == 3'd0) ? 3'd1 :
          (tx_used > 3'(hmv_pkg::MAX_TX)) ? 3'(hmv_pkg::MAX_TX) : tx_used;
    nsc = (sc_used == 9'd0) ? 9'd1 :
          (sc_used > 9'(hmv_pkg::MAX_SC)) ? 9'(hmv_pkg::MAX_SC) : sc_used;
  end

  assign accept  = in_valid && in_ready;
  assign total   = 12'(nrx) * 12'(nsc);
  assign ld_addr = (12'(load_pos) >= total) ? 12'd0 : 12'(load_pos);
  assign ld_next = ld_addr + 12'd1;
  assign rd_addr = AW'(12'(rx_pos) * 12'(nsc) + 12'(sc_pos));
  assign y_we    = accept && !req_type;
  assign y_rd    = accept && req_type;

  assign rx_more = (3'(rx_pos) + 3'd1) < nrx;
  assign sc_more = (9'(sc_pos) + 9'd1) < nsc;
  assign tx_more = (3'(tx_pos) + 3'd1) < ntx;

  // y memory
  always_ff @(posedge clk) begin
    if (y_we) begin
      ymem[ld_addr[AW-1:0]] <= {val_im, val_re};
    end
    if (y_rd) begin
      y_rdata <= ymem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (y_rd) begin
      h_re <= val_re;
      h_im <= val_im;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hmv_pkg::S_IDLE: if (y_rd) state_next = hmv_pkg::S_MUL;
      hmv_pkg::S_MUL:  if (step == 2'd3) state_next = hmv_pkg::S_ADD;
      hmv_pkg::S_ADD:  state_next = rx_more ? hmv_pkg::S_IDLE : hmv_pkg::S_EMIT;
      hmv_pkg::S_EMIT: if (emit_fire) state_next = hmv_pkg::S_IDLE;
      default:         state_next = hmv_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready         = 1'b0;
    emit_fire        = 1'b0;
    mac_ctrl.mul_en  = 1'b0;
    mac_ctrl.mul_sel = step;
    mac_ctrl.acc_clr = 1'b0;
    unique case (state)
      hmv_pkg::S_IDLE: in_ready = 1'b1;
      hmv_pkg::S_MUL:  mac_ctrl.mul_en = 1'b1;
      hmv_pkg::S_ADD:  ;
      hmv_pkg::S_EMIT: begin
        emit_fire        = !out_valid || out_ready;
        mac_ctrl.acc_clr = emit_fire;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hmv_pkg::S_IDLE;
      step  <= 2'd0;
    end else begin
      state <= state_next;
      step  <= (state == hmv_pkg::S_MUL) ? step + 2'd1 : 2'd0;
    end
  end

  // positions
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      rx_pos   <= '0;
      sc_pos   <= '0;
      tx_pos   <= '0;
    end else begin
      if (y_we) begin
        load_pos <= (ld_next >= total) ? '0 : ld_next[AW-1:0];
      end
      if (state == hmv_pkg::S_ADD && rx_more) begin
        rx_pos <= rx_pos + 2'd1;
      end
      if (emit_fire) begin
        rx_pos <= '0;
        if (sc_more) begin
          sc_pos <= sc_pos + 8'd1;
        end else begin
          sc_pos <= '0;
          tx_pos <= tx_more ? tx_pos + 2'd1 : 2'd0;
        end
      end
    end
  end

  hmv_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .h_re      (h_re),
    .h_im      (h_im),
    .y_re      (y_rdata[31:0]),
    .y_im      (y_rdata[63:32]),
    .frac_bits (frac_bits),
    .sum_re    (sum_re),
    .sum_im    (sum_im)
  );

  // output register, the next item may enter while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_re   <= sum_re;
      out_im   <= sum_im;
      tx_index <= tx_pos;
      sc_index <= sc_pos;
      last     <= !sc_more && !tx_more;
    end
  end

endmodule
